### src/esc_pkg.sv
// Shared types, constants and lookup functions for the epoch seconds to calendar converter.
package esc_pkg;

    localparam int SECONDS_BITS_DEF = 32;
    localparam int EPOCH_W          = 32;
    localparam int MILLIS_W         = 10;
    localparam int YEAR_W           = 12;
    localparam int MONTH_W          = 4;
    localparam int DAY_W            = 5;
    localparam int HOUR_W           = 5;
    localparam int MINUTE_W         = 6;
    localparam int SECOND_W         = 6;
    localparam int WEEKDAY_W        = 3;
    localparam int SPAN_W           = 25;
    localparam int S_TDATA_W        = 48;
    localparam int M_TDATA_W        = 56;

    localparam logic [YEAR_W-1:0]   FIRST_YEAR         = 12'd1970;
    localparam logic [1:0]          FIRST_Y4           = 2'd2;
    localparam logic [6:0]          FIRST_Y100         = 7'd70;
    localparam logic [8:0]          FIRST_Y400         = 9'd370;
    localparam logic [SPAN_W-1:0]   SECS_PER_YEAR      = 25'd31536000;
    localparam logic [SPAN_W-1:0]   SECS_PER_LEAP_YEAR = 25'd31622400;
    localparam logic [SPAN_W-1:0]   SECS_PER_DAY       = 25'd86400;
    localparam logic [SPAN_W-1:0]   SECS_PER_HOUR      = 25'd3600;
    localparam logic [SPAN_W-1:0]   SECS_PER_MINUTE    = 25'd60;
    localparam logic [MILLIS_W-1:0] MILLIS_MAX         = 10'd999;
    localparam logic [MONTH_W-1:0]  LAST_MONTH_IDX     = 4'd11;
    localparam logic [DAY_W-1:0]    SHORTEST_MONTH     = 5'd28;

    typedef struct packed {
        logic load;
        logic year_step;
        logic month_step;
        logic day_step;
        logic hour_step;
        logic minute_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic year_ge;
        logic month_go;
        logic day_ge;
        logic hour_ge;
        logic minute_ge;
    } sts_t;

    typedef struct packed {
        logic [WEEKDAY_W-1:0] weekday;
        logic [MILLIS_W-1:0]  millis_out;
        logic [SECOND_W-1:0]  second;
        logic [MINUTE_W-1:0]  minute;
        logic [HOUR_W-1:0]    hour;
        logic [DAY_W-1:0]     day;
        logic [MONTH_W-1:0]   month;
        logic [YEAR_W-1:0]    year;
    } result_t;

    function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                   input logic [MONTH_W-1:0] idx);
        logic [DAY_W-1:0] d;
        unique case (idx) inside
            4'd1:                       d = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:    d = 5'd30;
            default:                    d = 5'd31;
        endcase
        month_len = d;
    endfunction

    function automatic logic [SPAN_W-1:0] month_secs(input logic [DAY_W-1:0] len);
        logic [SPAN_W-1:0] s;
        unique case (len)
            5'd28:   s = 25'd2419200;
            5'd29:   s = 25'd2505600;
            5'd30:   s = 25'd2592000;
            default: s = 25'd2678400;
        endcase
        month_secs = s;
    endfunction

    function automatic logic [WEEKDAY_W-1:0] weekday_of(input logic [2:0] offset);
        logic [WEEKDAY_W-1:0] w;
        unique case (offset)
            3'd0:    w = 3'd4;
            3'd1:    w = 3'd5;
            3'd2:    w = 3'd6;
            3'd3:    w = 3'd7;
            3'd4:    w = 3'd1;
            3'd5:    w = 3'd2;
            3'd6:    w = 3'd3;
            default: w = 3'd4;
        endcase
        weekday_of = w;
    endfunction

endpackage

### src/esc_ctrl.sv
// Sequencer that steps the converter datapath through its subtract loops.
module esc_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          out_ready,
    output logic          out_valid,
    input  esc_pkg::sts_t sts,
    output esc_pkg::cmd_t cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_YEAR   = 7'b0000010,
        ST_MONTH  = 7'b0000100,
        ST_DAY    = 7'b0001000,
        ST_HOUR   = 7'b0010000,
        ST_MINUTE = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_YEAR;
                end
            end
            ST_YEAR: begin
                if (sts.year_ge) begin
                    cmd.year_step = 1'b1;
                end else begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH: begin
                if (sts.month_go) begin
                    cmd.month_step = 1'b1;
                end else begin
                    state_next = ST_DAY;
                end
            end
            ST_DAY: begin
                if (sts.day_ge) begin
                    cmd.day_step = 1'b1;
                end else begin
                    state_next = ST_HOUR;
                end
            end
            ST_HOUR: begin
                if (sts.hour_ge) begin
                    cmd.hour_step = 1'b1;
                end else begin
                    state_next = ST_MINUTE;
                end
            end
            ST_MINUTE: begin
                if (sts.minute_ge) begin
                    cmd.minute_step = 1'b1;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!out_valid_reg || out_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### src/esc_datapath.sv
// Datapath with the year, month, day, hour and minute subtract loops and the result register.
module esc_datapath #(
    parameter int SECONDS_BITS = esc_pkg::SECONDS_BITS_DEF
) (
    input  logic                           aclk,
    input  esc_pkg::cmd_t                  cmd,
    input  logic [esc_pkg::EPOCH_W-1:0]    epoch_seconds,
    input  logic [esc_pkg::MILLIS_W-1:0]   millis_in,
    output esc_pkg::sts_t                  sts,
    output esc_pkg::result_t               res
);

    logic [SECONDS_BITS-1:0]           s_reg, s_next;
    logic [2:0]                        wd_reg, wd_next;
    logic [esc_pkg::YEAR_W-1:0]        year_reg, year_next;
    logic [1:0]                        y4_reg, y4_next;
    logic [6:0]                        y100_reg, y100_next;
    logic [8:0]                        y400_reg, y400_next;
    logic [esc_pkg::MONTH_W-1:0]       month_reg, month_next;
    logic [esc_pkg::DAY_W-1:0]         day_reg, day_next;
    logic [esc_pkg::HOUR_W-1:0]        hour_reg, hour_next;
    logic [esc_pkg::MINUTE_W-1:0]      minute_reg, minute_next;
    logic [esc_pkg::MILLIS_W-1:0]      millis_reg, millis_next;
    esc_pkg::result_t                  res_reg, res_next;

    logic                              leap;
    logic [esc_pkg::SPAN_W-1:0]        sy;
    logic [esc_pkg::DAY_W-1:0]         ml;
    logic [esc_pkg::SPAN_W-1:0]        sm;
    logic [1:0]                        wd_adv;
    logic [3:0]                        wd_sum;
    logic [2:0]                        wd_wrap;

    assign leap    = ((y4_reg == 2'd0) && (y100_reg != 7'd0)) || (y400_reg == 9'd0);
    assign sy      = leap ? esc_pkg::SECS_PER_LEAP_YEAR : esc_pkg::SECS_PER_YEAR;
    assign ml      = esc_pkg::month_len(leap, month_reg);
    assign sm      = esc_pkg::month_secs(ml);
    assign wd_sum  = {1'b0, wd_reg} + {2'b00, wd_adv};
    assign wd_wrap = (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : wd_sum[2:0];

    assign sts.year_ge   = (s_reg >= SECONDS_BITS'(sy));
    assign sts.month_go  = (month_reg < esc_pkg::LAST_MONTH_IDX) &&
                           (s_reg >= SECONDS_BITS'(sm));
    assign sts.day_ge    = (s_reg >= SECONDS_BITS'(esc_pkg::SECS_PER_DAY));
    assign sts.hour_ge   = (s_reg >= SECONDS_BITS'(esc_pkg::SECS_PER_HOUR));
    assign sts.minute_ge = (s_reg >= SECONDS_BITS'(esc_pkg::SECS_PER_MINUTE));

    always_comb begin
        wd_adv = 2'd0;
        if (cmd.year_step) begin
            wd_adv = leap ? 2'd2 : 2'd1;
        end
        if (cmd.month_step) begin
            wd_adv = 2'(ml - esc_pkg::SHORTEST_MONTH);
        end
        if (cmd.day_step) begin
            wd_adv = 2'd1;
        end
    end

    always_comb begin
        s_next      = s_reg;
        wd_next     = wd_reg;
        year_next   = year_reg;
        y4_next     = y4_reg;
        y100_next   = y100_reg;
        y400_next   = y400_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        millis_next = millis_reg;
        res_next    = res_reg;
        if (cmd.load) begin
            s_next      = SECONDS_BITS'(epoch_seconds);
            wd_next     = '0;
            year_next   = esc_pkg::FIRST_YEAR;
            y4_next     = esc_pkg::FIRST_Y4;
            y100_next   = esc_pkg::FIRST_Y100;
            y400_next   = esc_pkg::FIRST_Y400;
            month_next  = '0;
            day_next    = '0;
            hour_next   = '0;
            minute_next = '0;
            millis_next = (millis_in > esc_pkg::MILLIS_MAX) ? esc_pkg::MILLIS_MAX : millis_in;
        end
        if (cmd.year_step) begin
            s_next    = s_reg - SECONDS_BITS'(sy);
            wd_next   = wd_wrap;
            year_next = year_reg + 1'b1;
            y4_next   = y4_reg + 1'b1;
            y100_next = (y100_reg == 7'd99) ? 7'd0 : y100_reg + 1'b1;
            y400_next = (y400_reg == 9'd399) ? 9'd0 : y400_reg + 1'b1;
        end
        if (cmd.month_step) begin
            s_next     = s_reg - SECONDS_BITS'(sm);
            wd_next    = wd_wrap;
            month_next = month_reg + 1'b1;
        end
        if (cmd.day_step) begin
            s_next   = s_reg - SECONDS_BITS'(esc_pkg::SECS_PER_DAY);
            wd_next  = wd_wrap;
            day_next = day_reg + 1'b1;
        end
        if (cmd.hour_step) begin
            s_next    = s_reg - SECONDS_BITS'(esc_pkg::SECS_PER_HOUR);
            hour_next = hour_reg + 1'b1;
        end
        if (cmd.minute_step) begin
            s_next      = s_reg - SECONDS_BITS'(esc_pkg::SECS_PER_MINUTE);
            minute_next = minute_reg + 1'b1;
        end
        if (cmd.load_out) begin
            res_next.year       = year_reg;
            res_next.month      = month_reg + 1'b1;
            res_next.day        = day_reg + 1'b1;
            res_next.hour       = hour_reg;
            res_next.minute     = minute_reg;
            res_next.second     = s_reg[esc_pkg::SECOND_W-1:0];
            res_next.millis_out = millis_reg;
            res_next.weekday    = esc_pkg::weekday_of(wd_reg);
        end
    end

    always_ff @(posedge aclk) begin
        s_reg      <= s_next;
        wd_reg     <= wd_next;
        year_reg   <= year_next;
        y4_reg     <= y4_next;
        y100_reg   <= y100_next;
        y400_reg   <= y400_next;
        month_reg  <= month_next;
        day_reg    <= day_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        millis_reg <= millis_next;
        res_reg    <= res_next;
    end

    assign res = res_reg;

endmodule

### src/epoch_seconds_to_calendar_top.sv
// Top level of the epoch seconds to Gregorian calendar converter.
// One beat is converted at a time. After a beat is taken the block subtracts whole years
// of seconds from 1970 up, one year per cycle, then whole months, days, hours and minutes,
// one per cycle each, keeping the weekday as it goes, and then enters a finish state that
// loads the result register once the output register is empty or being read. Wider seconds
// lengthen the year loop. A new beat is taken as soon as the result has moved into the
// output register, even while that result still waits.
module epoch_seconds_to_calendar_top #(
    parameter int SECONDS_BITS = esc_pkg::SECONDS_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // epoch_seconds [31:0], millis_in [41:32], zero fill above.
    input  logic [esc_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // year [11:0], month [15:12], day [20:16], hour [25:21], minute [31:26],
    // second [37:32], millis_out [47:38], weekday [50:48], zero fill above.
    output logic [esc_pkg::M_TDATA_W-1:0] m_tdata
);

    esc_pkg::cmd_t    cmd;
    esc_pkg::sts_t    sts;
    esc_pkg::result_t res;

    esc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .sts       (sts),
        .cmd       (cmd)
    );

    esc_datapath #(
        .SECONDS_BITS (SECONDS_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .cmd           (cmd),
        .epoch_seconds (s_tdata[esc_pkg::EPOCH_W-1:0]),
        .millis_in     (s_tdata[esc_pkg::EPOCH_W +: esc_pkg::MILLIS_W]),
        .sts           (sts),
        .res           (res)
    );

    assign m_tdata = {5'd0, res.weekday, res.millis_out, res.second, res.minute,
                      res.hour, res.day, res.month, res.year};

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("A second beat was taken while a conversion was running.");

    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:12] >= 4'd1) && (m_tdata[15:12] <= 4'd12))
        else $error("Month of a result beat is out of range.");

    a_day_weekday: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[20:16] != 5'd0) && (m_tdata[50:48] != 3'd0))
        else $error("Day or weekday of a result beat is zero.");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("Handshake outputs are not idle after reset.");

endmodule
